@@ hw/rtl/rhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types and constants for the RTP header parser.
// ----------------------------------------------------------------------------
package rhp_pkg;

	localparam logic [15:0] HDR_LEN     = 16'd12;
	localparam logic [15:0] CNT_MAX     = 16'hFFFF;
	localparam logic [15:0] MAX_LEN_RST = 16'd1500;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_LONG     = 3'd2;
	localparam logic [2:0] ST_CSRC     = 3'd3;
	localparam logic [2:0] ST_EXT_HDR  = 3'd4;
	localparam logic [2:0] ST_EXT_LEN  = 3'd5;
	localparam logic [2:0] ST_PAD_EMPT = 3'd6;
	localparam logic [2:0] ST_PAD_LEN  = 3'd7;

	// register index
	localparam logic REG_MAX_LENGTH = 1'b0;

	// everything the checker needs from one packet, taken on its last byte
	typedef struct packed {
		logic [16:0] len;
		logic        ovf;
		logic [7:0]  hdr0;
		logic [7:0]  hdr1;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [31:0] src;
		logic [15:0] ext_words;
		logic [7:0]  pad_bytes;
	} pkt_t;

endpackage

@@ hw/rtl/rhp_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_cfg
// APB register file holding the maximum packet length.
// ----------------------------------------------------------------------------
module rhp_cfg import rhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] max_length
);

	logic [15:0] max_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LEN_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_LENGTH)) begin
			max_length_q <= pwdata[15:0];
		end
	end

	assign prdata     = (paddr[2] == REG_MAX_LENGTH) ? {16'd0, max_length_q} : 32'd0;
	assign pready     = 1'b1;
	assign max_length = max_length_q;

endmodule

@@ hw/rtl/rhp_capture.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_capture
// Byte counter and header capture; snapshots the packet on its last byte.
// ----------------------------------------------------------------------------
module rhp_capture import rhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output pkt_t       pkt_s1
);

	logic [15:0] cnt_q;
	logic        ovf_q;
	logic [7:0]  hdr0_q;
	logic [7:0]  hdr1_q;
	logic [15:0] seq_q;
	logic [31:0] ts_q;
	logic [31:0] src_q;
	logic [15:0] ext_q;

	logic [7:0]  hdr0_n;
	logic [7:0]  hdr1_n;
	logic [15:0] seq_n;
	logic [31:0] ts_n;
	logic [31:0] src_n;
	logic [15:0] ext_n;
	logic [15:0] ext_pos;
	logic        cap;

	// extension length word sits after the CSRC list plus two bytes
	assign ext_pos = HDR_LEN + {10'd0, hdr0_q[3:0], 2'b00} + 16'd2;
	assign cap     = !ovf_q;

	always_comb begin
		hdr0_n = hdr0_q;
		hdr1_n = hdr1_q;
		seq_n  = seq_q;
		ts_n   = ts_q;
		src_n  = src_q;
		ext_n  = ext_q;
		if (cap) begin
			if (cnt_q == 16'd0) begin
				hdr0_n = data_byte;
			end else if (cnt_q == 16'd1) begin
				hdr1_n = data_byte;
			end else if (cnt_q < 16'd4) begin
				seq_n = {seq_q[7:0], data_byte};
			end else if (cnt_q < 16'd8) begin
				ts_n = {ts_q[23:0], data_byte};
			end else if (cnt_q < HDR_LEN) begin
				src_n = {src_q[23:0], data_byte};
			end else if (cnt_q == ext_pos) begin
				ext_n = {data_byte, 8'd0};
			end else if (cnt_q == ext_pos + 16'd1) begin
				ext_n = {ext_q[15:8], data_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			hdr0_q <= '0;
			hdr1_q <= '0;
			seq_q  <= '0;
			ts_q   <= '0;
			src_q  <= '0;
			ext_q  <= '0;
		end else if (accept) begin
			if (last_byte) begin
				// clear for the next packet
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
				hdr0_q <= '0;
				hdr1_q <= '0;
				seq_q  <= '0;
				ts_q   <= '0;
				src_q  <= '0;
				ext_q  <= '0;
			end else begin
				hdr0_q <= hdr0_n;
				hdr1_q <= hdr1_n;
				seq_q  <= seq_n;
				ts_q   <= ts_n;
				src_q  <= src_n;
				ext_q  <= ext_n;
				// saturate the counter
				if (cnt_q == CNT_MAX) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			pkt_s1.len       <= {1'b0, cnt_q} + 17'd1;
			pkt_s1.ovf       <= ovf_q;
			pkt_s1.hdr0      <= hdr0_n;
			pkt_s1.hdr1      <= hdr1_n;
			pkt_s1.seq       <= seq_n;
			pkt_s1.ts        <= ts_n;
			pkt_s1.src       <= src_n;
			pkt_s1.ext_words <= ext_n;
			pkt_s1.pad_bytes <= data_byte;
		end
	end

endmodule

@@ hw/rtl/rhp_result.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_result
// Length checks, payload offset and length, and the result register.
// ----------------------------------------------------------------------------
module rhp_result import rhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pkt_t        pkt_s1,
	input  logic        valid_s1,
	input  logic        advance,
	input  logic [15:0] max_length,
	output logic        out_valid,
	output logic [2:0]  status,
	output logic [1:0]  version,
	output logic        padding_flag,
	output logic        extension_flag,
	output logic [3:0]  csrc_count,
	output logic        marker,
	output logic [6:0]  payload_type,
	output logic [15:0] sequence_number,
	output logic [31:0] media_timestamp,
	output logic [31:0] source_id,
	output logic [15:0] payload_offset,
	output logic [15:0] payload_length
);

	logic        valid_q;
	logic [2:0]  status_q;
	logic [15:0] offset_q;
	logic [15:0] plen_q;
	pkt_t        pkt_q;

	logic        ext;
	logic        pad;
	logic [3:0]  cc;
	logic [15:0] cc4;
	logic [17:0] esz;
	logic [15:0] rem0;
	logic [15:0] rem1;
	logic [15:0] rem2;
	logic [15:0] rem3;
	logic [15:0] offset;
	logic [15:0] plen;
	logic [2:0]  st;

	assign cc   = pkt_s1.hdr0[3:0];
	assign ext  = pkt_s1.hdr0[4];
	assign pad  = pkt_s1.hdr0[5];
	assign cc4  = {10'd0, cc, 2'b00};
	assign esz  = {pkt_s1.ext_words, 2'b00};
	assign rem0 = pkt_s1.len[15:0] - HDR_LEN;
	assign rem1 = rem0 - cc4;
	assign rem2 = rem1 - 16'd4;
	assign rem3 = ext ? (rem2 - esz[15:0]) : rem1;
	assign plen = pad ? (rem3 - {8'd0, pkt_s1.pad_bytes}) : rem3;

	always_comb begin
		if (pkt_s1.len < {1'b0, HDR_LEN}) begin
			st = ST_SHORT;
		end else if (pkt_s1.ovf || pkt_s1.len[16] || (pkt_s1.len > {1'b0, max_length})) begin
			st = ST_LONG;
		end else if ((cc != 4'd0) && (rem0 <= cc4)) begin
			st = ST_CSRC;
		end else if (ext && (rem1 <= 16'd4)) begin
			st = ST_EXT_HDR;
		end else if (ext && ({2'b00, rem2} <= esz)) begin
			st = ST_EXT_LEN;
		end else if (pad && (rem3 == 16'd0)) begin
			st = ST_PAD_EMPT;
		end else if (pad && (rem3 <= {8'd0, pkt_s1.pad_bytes})) begin
			st = ST_PAD_LEN;
		end else begin
			st = ST_OK;
		end
	end

	// on a good packet the offset stays below the length, so 16 bits hold it
	assign offset = HDR_LEN + cc4 + (ext ? (16'd4 + esz[15:0]) : 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_q <= st;
			offset_q <= (st == ST_OK) ? offset : 16'd0;
			plen_q   <= (st == ST_OK) ? plen : 16'd0;
			pkt_q    <= pkt_s1;
		end
	end

	assign out_valid       = valid_q;
	assign status          = status_q;
	assign version         = pkt_q.hdr0[7:6];
	assign padding_flag    = pkt_q.hdr0[5];
	assign extension_flag  = pkt_q.hdr0[4];
	assign csrc_count      = pkt_q.hdr0[3:0];
	assign marker          = pkt_q.hdr1[7];
	assign payload_type    = pkt_q.hdr1[6:0];
	assign sequence_number = pkt_q.seq;
	assign media_timestamp = pkt_q.ts;
	assign source_id       = pkt_q.src;
	assign payload_offset  = offset_q;
	assign payload_length  = plen_q;

endmodule

@@ hw/rtl/rtp_header_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_header_parser
// Byte-serial RTP packet parser: one result per packet on its last byte.
// Throughput: one byte per cycle, back to back across packets, while out_ready
//   lets results drain. The last byte goes to the snapshot register, then
//   through the check logic into the result register.
// Reset clears the byte counter and header state; max_length resets to 1500.
// ----------------------------------------------------------------------------
module rtp_header_parser import rhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  version,
	output logic        padding_flag,
	output logic        extension_flag,
	output logic [3:0]  csrc_count,
	output logic        marker,
	output logic [6:0]  payload_type,
	output logic [15:0] sequence_number,
	output logic [31:0] media_timestamp,
	output logic [31:0] source_id,
	output logic [15:0] payload_offset,
	output logic [15:0] payload_length
);

	logic [15:0] max_length;
	logic        accept;
	logic        advance;
	logic        valid_s1;
	pkt_t        pkt_s1;

	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// snapshot stage valid: load on a last byte, drain into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	rhp_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.max_length (max_length)
	);

	rhp_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.pkt_s1    (pkt_s1)
	);

	rhp_result u_result (
		.clk             (clk),
		.arst_n          (arst_n),
		.pkt_s1          (pkt_s1),
		.valid_s1        (valid_s1),
		.advance         (advance),
		.max_length      (max_length),
		.out_valid       (out_valid),
		.status          (status),
		.version         (version),
		.padding_flag    (padding_flag),
		.extension_flag  (extension_flag),
		.csrc_count      (csrc_count),
		.marker          (marker),
		.payload_type    (payload_type),
		.sequence_number (sequence_number),
		.media_timestamp (media_timestamp),
		.source_id       (source_id),
		.payload_offset  (payload_offset),
		.payload_length  (payload_length)
	);

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-serial RTP header parser. Packets are
// streamed one byte per request under random idling on both handshakes. An
// in-bench parser predicts every header result and checks it field by
// field, across several max_length settings from below the header size up
// to the full 16-bit range.
// ----------------------------------------------------------------------------
module tb;
	import rhp_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} rtp_byte_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  version;
		logic        pad;
		logic        ext;
		logic [3:0]  cc;
		logic        marker;
		logic [6:0]  ptype;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [31:0] ssrc;
		logic [15:0] offset;
		logic [15:0] plen;
	} rtp_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [1:0]  version;
	logic        padding_flag;
	logic        extension_flag;
	logic [3:0]  csrc_count;
	logic        marker;
	logic [6:0]  payload_type;
	logic [15:0] sequence_number;
	logic [31:0] media_timestamp;
	logic [31:0] source_id;
	logic [15:0] payload_offset;
	logic [15:0] payload_length;

	rtp_header_parser DUT (.*);

	always #2 clk = ~clk;

	// parser state of the predictor
	logic [15:0] pos_count = '0;
	logic        pos_saturated = 1'b0;
	logic [7:0]  hdr_b0 = '0;
	logic [7:0]  hdr_b1 = '0;
	logic [15:0] seq_acc = '0;
	logic [31:0] ts_acc = '0;
	logic [31:0] ssrc_acc = '0;
	logic [15:0] ext_acc = '0;
	logic [15:0] max_len_cfg = MAX_LEN_RST;

	rtp_byte_t   byte_q[$];
	rtp_result_t expected_headers[$];
	int unsigned bytes_queued = 0;
	int unsigned bytes_taken = 0;
	int unsigned headers_checked = 0;
	int unsigned mismatches = 0;
	int unsigned status_seen[8] = '{default: 0};
	bit          byte_taken = 1'b0;
	int unsigned send_gap = 0;
	int unsigned hold_gap = 0;
	int          idle_mode = 1;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("tb: mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
		mismatches++;
	endtask

	// mode 0: no idling, 1: mostly short gaps with a few long ones, 2: short only
	function automatic int unsigned pick_gap(input int mode);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (mode == 0) return 0;
		if (mode == 2) return (r < 90) ? 0 : 1;
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic parse_rtp_byte(input logic [7:0] b, input logic fin);
		int unsigned idx, len, csrc_end, offset, remain, ext_bytes;
		rtp_result_t r;
		idx = pos_count;
		if (!pos_saturated) begin
			csrc_end = HDR_LEN + 4 * hdr_b0[3:0];
			if (idx == 0) hdr_b0 = b;
			else if (idx == 1) hdr_b1 = b;
			else if (idx < 4) seq_acc = {seq_acc[7:0], b};
			else if (idx < 8) ts_acc = {ts_acc[23:0], b};
			else if (idx < 12) ssrc_acc = {ssrc_acc[23:0], b};
			else if (idx == csrc_end + 2) ext_acc = {b, 8'h00};
			else if (idx == csrc_end + 3) ext_acc[7:0] = b;
		end
		if (!fin) begin
			if (pos_count == CNT_MAX) pos_saturated = 1'b1;
			else pos_count = pos_count + 16'd1;
		end else begin
			len = idx + 1;
			r = '0;
			r.status = ST_OK;
			r.version = hdr_b0[7:6];
			r.pad = hdr_b0[5];
			r.ext = hdr_b0[4];
			r.cc = hdr_b0[3:0];
			r.marker = hdr_b1[7];
			r.ptype = hdr_b1[6:0];
			r.seq = seq_acc;
			r.ts = ts_acc;
			r.ssrc = ssrc_acc;
			offset = 0;
			remain = 0;
			if (len < HDR_LEN) r.status = ST_SHORT;
			else if (pos_saturated || len > CNT_MAX || len > max_len_cfg) r.status = ST_LONG;
			else begin
				offset = HDR_LEN;
				remain = len - HDR_LEN;
				if (r.cc != 0) begin
					if (remain <= 4 * r.cc) r.status = ST_CSRC;
					else begin
						offset += 4 * r.cc;
						remain -= 4 * r.cc;
					end
				end
				if (r.status == ST_OK && r.ext) begin
					if (remain <= 4) r.status = ST_EXT_HDR;
					else begin
						ext_bytes = 4 * ext_acc;
						offset += 4;
						remain -= 4;
						if (remain <= ext_bytes) r.status = ST_EXT_LEN;
						else begin
							offset += ext_bytes;
							remain -= ext_bytes;
						end
					end
				end
				// trailing padding count sits in the final byte
				if (r.status == ST_OK && r.pad) begin
					if (remain == 0) r.status = ST_PAD_EMPT;
					else if (remain <= b) r.status = ST_PAD_LEN;
					else remain -= b;
				end
				if (r.status == ST_OK) begin
					r.offset = offset[15:0];
					r.plen = remain[15:0];
				end
			end
			expected_headers.push_back(r);
			pos_count = '0;
			pos_saturated = 1'b0;
			hdr_b0 = '0;
			hdr_b1 = '0;
			seq_acc = '0;
			ts_acc = '0;
			ssrc_acc = '0;
			ext_acc = '0;
		end
	endtask

	// sender side
	always @(negedge clk) begin
		if (arst_n && (!in_valid || byte_taken)) begin
			byte_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (byte_q.size() > 0) begin
				in_valid <= 1'b1;
				data_byte <= byte_q[0].value;
				last_byte <= byte_q[0].fin;
				void'(byte_q.pop_front());
				send_gap = pick_gap(idle_mode);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver side
	always @(negedge clk) begin
		if (hold_gap > 0) begin
			out_ready <= 1'b0;
			hold_gap--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) hold_gap = pick_gap(idle_mode);
		end
	end

	always @(posedge clk) begin
		rtp_result_t e;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_rtp_byte(data_byte, last_byte);
				bytes_taken++;
				byte_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (expected_headers.size() == 0) begin
					report_mismatch("unexpected result", {29'd0, status}, 32'd0);
				end else begin
					e = expected_headers.pop_front();
					if (status !== e.status) report_mismatch("status", status, e.status);
					if (version !== e.version) report_mismatch("version", version, e.version);
					if (padding_flag !== e.pad) report_mismatch("padding_flag", padding_flag, e.pad);
					if (extension_flag !== e.ext)
						report_mismatch("extension_flag", extension_flag, e.ext);
					if (csrc_count !== e.cc) report_mismatch("csrc_count", csrc_count, e.cc);
					if (marker !== e.marker) report_mismatch("marker", marker, e.marker);
					if (payload_type !== e.ptype)
						report_mismatch("payload_type", payload_type, e.ptype);
					if (sequence_number !== e.seq)
						report_mismatch("sequence_number", sequence_number, e.seq);
					if (media_timestamp !== e.ts)
						report_mismatch("media_timestamp", media_timestamp, e.ts);
					if (source_id !== e.ssrc) report_mismatch("source_id", source_id, e.ssrc);
					if (payload_offset !== e.offset)
						report_mismatch("payload_offset", payload_offset, e.offset);
					if (payload_length !== e.plen)
						report_mismatch("payload_length", payload_length, e.plen);
					status_seen[e.status]++;
					headers_checked++;
				end
			end
		end
	end

	task automatic set_max_length(input logic [15:0] v);
		logic [31:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_MAX_LENGTH);
		pwdata <= {16'h0000, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		max_len_cfg = v;
		// read it back
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[15:0] !== v) report_mismatch("max_length readback", rd, {16'h0000, v});
	endtask

	// hold until every byte is taken and every result is in, then let the pipe settle
	task automatic wait_idle();
		while (bytes_taken != bytes_queued) @(posedge clk);
		while (expected_headers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_bytes(ref logic [7:0] pkt[$]);
		rtp_byte_t item;
		foreach (pkt[i]) begin
			item.value = pkt[i];
			item.fin = (i == pkt.size() - 1);
			byte_q.push_back(item);
		end
		bytes_queued += pkt.size();
	endtask

	// header, CSRC list, optional extension, body; last_val >= 0 overrides the final
	// byte, cut > 0 truncates the packet to that many bytes
	task automatic queue_packet(input logic [7:0] b0, input logic [7:0] b1, input int ext_len,
			input int body, input int last_val, input int cut);
		logic [7:0]  pkt[$];
		logic [15:0] ewords;
		ewords = ext_len;
		pkt.push_back(b0);
		pkt.push_back(b1);
		repeat (10) pkt.push_back(8'($urandom));
		repeat (4 * b0[3:0]) pkt.push_back(8'($urandom));
		if (b0[4]) begin
			pkt.push_back(8'($urandom));
			pkt.push_back(8'($urandom));
			pkt.push_back(ewords[15:8]);
			pkt.push_back(ewords[7:0]);
			repeat (4 * ext_len) pkt.push_back(8'($urandom));
		end
		repeat (body) pkt.push_back(8'($urandom));
		if (last_val >= 0) pkt[pkt.size() - 1] = 8'(last_val);
		if (cut > 0) while (pkt.size() > cut) void'(pkt.pop_back());
		queue_bytes(pkt);
	endtask

	task automatic queue_random_packet();
		logic [7:0] b0;
		logic [7:0] pkt[$];
		int kind, body, ext_len, last_val, cut, full, pick;
		kind = $urandom_range(0, 99);
		b0 = 8'($urandom);
		if (kind < 85) begin
			if ($urandom_range(0, 9) != 0) b0[7:6] = 2'd2;
			pick = $urandom_range(0, 9);
			if (pick < 5) b0[3:0] = 4'd0;
			else if (pick < 9) b0[3:0] = 4'($urandom_range(1, 3));
			ext_len = $urandom_range(0, 3);
			body = $urandom_range(0, 20);
			last_val = b0[5] ? $urandom_range(0, body + 1) : -1;
			full = 12 + 4 * b0[3:0] + (b0[4] ? 4 + 4 * ext_len : 0) + body;
			cut = (kind >= 70) ? $urandom_range(1, full) : 0;
			queue_packet(b0, 8'($urandom), ext_len, body, last_val, cut);
		end else begin
			// raw noise of random bytes
			repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
			queue_bytes(pkt);
		end
	endtask

	task automatic run_random(input int unsigned budget);
		int unsigned start;
		start = bytes_queued;
		while (bytes_queued - start < budget) queue_random_packet();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset value of max_length
		queue_packet(8'h80, 8'h00, 0, 0, -1, 0);
		queue_packet(8'hFF, 8'hFF, 1, 10, 3, 0);
		queue_packet(8'h80, 8'h80, 0, 0, -1, 1);
		queue_packet(8'h80, 8'h7F, 0, 0, -1, 11);
		queue_packet(8'h8F, 8'h11, 0, 0, -1, 12 + 60);
		queue_packet(8'h8F, 8'h12, 0, 2, -1, 0);
		queue_packet(8'h90, 8'h13, 0, 0, -1, 16);
		queue_packet(8'h90, 8'h14, 2, 0, -1, 12 + 4 + 8);
		queue_packet(8'h90, 8'h15, 0, 5, -1, 0);
		queue_packet(8'hA0, 8'h16, 0, 0, -1, 0);
		queue_packet(8'hA0, 8'h17, 0, 4, 4, 0);
		queue_packet(8'hA0, 8'h18, 0, 4, 3, 0);
		queue_packet(8'hA0, 8'h19, 0, 3, 0, 0);
		queue_packet(8'hA0, 8'h1A, 0, 3, 255, 0);
		queue_packet(8'h00, 8'h1B, 0, 2, -1, 0);
		queue_packet(8'h40, 8'h1C, 0, 2, -1, 0);
		queue_packet(8'hC0, 8'h1D, 0, 2, -1, 0);
		wait_idle();

		set_max_length(16'd12);
		run_random(50);
		wait_idle();

		set_max_length(16'd7);
		run_random(40);
		wait_idle();

		set_max_length(16'($urandom_range(24, 80)));
		run_random(100);
		wait_idle();

		idle_mode = 0;
		set_max_length(MAX_LEN_RST);
		run_random(100);
		wait_idle();

		idle_mode = 1;
		set_max_length(CNT_MAX);
		run_random(60);
		wait_idle();

		idle_mode = 2;
		run_random(40);
		wait_idle();

		$display("tb: %0d bytes taken, %0d headers checked, max_length 7, 12, mid, 1500, 65535",
			bytes_taken, headers_checked);
		$display("tb: status seen ok %0d short %0d long %0d csrc %0d ext %0d/%0d pad %0d/%0d",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_LONG],
			status_seen[ST_CSRC], status_seen[ST_EXT_HDR], status_seen[ST_EXT_LEN],
			status_seen[ST_PAD_EMPT], status_seen[ST_PAD_LEN]);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: timeout with %0d results outstanding", expected_headers.size());
		$display("tb: failure");
		$finish;
	end

endmodule
